### design/svs_pkg.sv
`timescale 1ns / 1ps
// types, constants and helpers shared by the skinning core
// no dependencies
package svs_pkg;

  localparam int WORDS_PER_BONE = 12;
  localparam int ONE_Q16        = 65536;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_WEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_FETCH,
    ST_DRAIN,
    ST_EMIT
  } svs_state_e;

  typedef struct packed {
    logic       in_ready;
    logic       accept;
    logic       load_wr;
    logic       rd_valid;
    logic [3:0] rd_word;
    logic       emit;
  } svs_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_is_weight;
    logic in_bone_ok;
    logic in_last;
    logic last_q;
    logic rows_done;
    logic out_free;
  } svs_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

### design/svs_in_if.sv
`timescale 1ns / 1ps
// input channel of the skinning core: valid/ready plus one item
// no dependencies
interface svs_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [10:0]        bone_slot;
  logic signed [31:0] new_value;
  logic signed [31:0] old_value;
  logic [6:0]         bone_index;
  logic [16:0]        weight;
  logic signed [31:0] offset_x;
  logic signed [31:0] offset_y;
  logic signed [31:0] offset_z;
  logic [31:0]        normal_packed_xy;
  logic signed [15:0] normal_z;
  logic               last_weight;

  modport source (output valid, command, bone_slot, new_value, old_value, bone_index,
                  weight, offset_x, offset_y, offset_z, normal_packed_xy, normal_z,
                  last_weight, input ready);
  modport sink (input valid, command, bone_slot, new_value, old_value, bone_index,
                weight, offset_x, offset_y, offset_z, normal_packed_xy, normal_z,
                last_weight, output ready);
endinterface

### design/svs_out_if.sv
`timescale 1ns / 1ps
// output channel of the skinning core: valid/ready plus skinned vertex
// no dependencies
interface svs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] norm_x;
  logic signed [31:0] norm_y;
  logic signed [31:0] norm_z;

  modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, output ready);
endinterface

### design/svs_ram.sv
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies
module svs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### design/svs_ctrl.sv
`timescale 1ns / 1ps
// sequencer of the skinning core: accepts words, walks the 12 matrix words
// depends on svs_pkg
module svs_ctrl
  import svs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  svs_stat_t stat_i,
  output svs_cmd_t  cmd_o
);

  svs_state_e state_q, state_d;
  logic [3:0] k_q, k_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    unique case (state_q)
      ST_IDLE: begin
        if (stat_i.in_valid) begin
          if (!stat_i.in_is_weight) begin
            state_d = ST_LOAD;
          end else if (stat_i.in_bone_ok) begin
            state_d = ST_FETCH;
          end else if (stat_i.in_last) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_LOAD: state_d = ST_IDLE;
      ST_FETCH: begin
        if (k_q == 4'd11) begin
          k_d     = '0;
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + 4'd1;
        end
      end
      ST_DRAIN: begin
        if (stat_i.rows_done) begin
          state_d = stat_i.last_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.accept   = stat_i.in_valid;
      end
      ST_LOAD: cmd_o.load_wr = 1'b1;
      ST_FETCH: begin
        cmd_o.rd_valid = 1'b1;
        cmd_o.rd_word  = k_q;
      end
      ST_DRAIN: cmd_o = '0;
      ST_EMIT: cmd_o.emit = stat_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  a_word_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_valid |-> cmd_o.rd_word <= 4'd11)
    else $error("matrix word index out of range");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> stat_i.out_free)
    else $error("emit into a full output register");

  a_weight_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && stat_i.in_is_weight && stat_i.in_bone_ok) |=> state_q == ST_FETCH)
    else $error("weight word did not start a fetch");

endmodule

### design/svs_datapath.sv
`timescale 1ns / 1ps
// datapath of the skinning core: bone blend, palette, row multiply-accumulate, sums
// depends on svs_pkg, svs_ram, svs_in_if, svs_out_if
module svs_datapath
  import svs_pkg::*;
#(
  parameter int MAX_BONES = 128
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [16:0]  cfg_wdata_i,
  input  svs_cmd_t     cmd_i,
  output svs_stat_t    stat_o,
  svs_in_if.sink       in_i,
  svs_out_if.source    out_o
);

  localparam int Depth = MAX_BONES * WORDS_PER_BONE;
  localparam int AW    = $clog2(Depth);

  logic [16:0] frac_q;

  // captured item
  logic signed [50:0] pnew_q, pold_q;
  logic [AW-1:0]      waddr_q, base_q;
  logic               slot_ok_q, last_q;
  logic signed [31:0] off_q [3];
  logic signed [15:0] nrm_q [3];
  logic [16:0]        w_q;

  logic [17:0]        onem;
  logic signed [51:0] bsum;
  logic signed [31:0] blend;
  logic [31:0]        rdata;

  // pipeline
  logic               v1_q, v2_q, v3_q, v4_q;
  logic [3:0]         k1_q, k2_q;
  logic [1:0]         r3_q, r4_q;
  logic signed [31:0] m, m2_q, off_sel;
  logic signed [15:0] nrm_sel;
  logic signed [63:0] pp2_q;
  logic signed [47:0] pn2_q, prnd;
  logic signed [49:0] pacc_q, nacc_q, pfin_q, nfin_q;
  logic signed [51:0] nr;
  logic signed [31:0] ps, ns;
  logic signed [49:0] wp_q, wn_q, rwp, rwn;
  logic signed [31:0] psum_q [3];
  logic signed [31:0] nsum_q [3];
  logic               out_valid_q;
  logic signed [31:0] opx_q, opy_q, opz_q, onx_q, ony_q, onz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q <= '0;
    end else if (cfg_we_i) begin
      frac_q <= (cfg_wdata_i > 17'(ONE_Q16)) ? 17'(ONE_Q16) : cfg_wdata_i;
    end
  end

  assign onem = 18'(ONE_Q16) - 18'(frac_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pnew_q    <= 51'(in_i.new_value) * 51'($signed({1'b0, onem}));
      pold_q    <= 51'(in_i.old_value) * 51'($signed({2'b0, frac_q}));
      waddr_q   <= AW'(32'(in_i.bone_slot));
      slot_ok_q <= 32'(in_i.bone_slot) < 32'(Depth);
      base_q    <= AW'(32'(in_i.bone_index) * 32'(WORDS_PER_BONE));
      off_q[0]  <= in_i.offset_x;
      off_q[1]  <= in_i.offset_y;
      off_q[2]  <= in_i.offset_z;
      nrm_q[0]  <= $signed(in_i.normal_packed_xy[31:16]);
      nrm_q[1]  <= $signed(in_i.normal_packed_xy[15:0]);
      nrm_q[2]  <= in_i.normal_z;
      w_q       <= (in_i.weight > 17'(ONE_Q16)) ? 17'(ONE_Q16) : in_i.weight;
      last_q    <= in_i.last_weight;
    end
  end

  assign bsum  = (52'(pnew_q) + 52'(pold_q) + 52'sd32768) >>> 16;
  assign blend = sat32(64'(bsum));

  svs_ram #(
    .WIDTH(32),
    .DEPTH(Depth)
  ) u_palette (
    .clk_i  (clk_i),
    .we_i   (cmd_i.load_wr && slot_ok_q),
    .waddr_i(waddr_q),
    .wdata_i(blend),
    .raddr_i(base_q + AW'(cmd_i.rd_word)),
    .rdata_o(rdata)
  );

  assign m = $signed(rdata);

  always_comb begin
    case (k1_q[1:0])
      2'd0: begin off_sel = off_q[0]; nrm_sel = nrm_q[0]; end
      2'd1: begin off_sel = off_q[1]; nrm_sel = nrm_q[1]; end
      2'd2: begin off_sel = off_q[2]; nrm_sel = nrm_q[2]; end
      default: begin off_sel = '0; nrm_sel = '0; end
    endcase
  end

  assign prnd = 48'((pp2_q + 64'sd32768) >>> 16);
  assign nr   = (52'(nfin_q) + 52'sd8192) >>> 14;
  assign ps   = sat32(64'(pfin_q));
  assign ns   = sat32(64'(nr));
  assign rwp  = (wp_q + 50'sd32768) >>> 16;
  assign rwn  = (wn_q + 50'sd32768) >>> 16;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      pacc_q <= '0;
      nacc_q <= '0;
      for (int i = 0; i < 3; i++) begin
        psum_q[i] <= '0;
        nsum_q[i] <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.rd_valid;
      v2_q <= v1_q;
      v3_q <= v2_q && (k2_q[1:0] == 2'd3);
      v4_q <= v3_q;
      // row accumulate; translation word closes the row
      if (v2_q) begin
        if (k2_q[1:0] == 2'd3) begin
          pacc_q <= '0;
          nacc_q <= '0;
        end else begin
          pacc_q <= pacc_q + 50'(prnd);
          nacc_q <= nacc_q + 50'(pn2_q);
        end
      end
      if (cmd_i.emit) begin
        for (int i = 0; i < 3; i++) begin
          psum_q[i] <= '0;
          nsum_q[i] <= '0;
        end
      end else if (v4_q) begin
        psum_q[r4_q] <= sat32(64'(psum_q[r4_q]) + 64'(rwp));
        nsum_q[r4_q] <= sat32(64'(nsum_q[r4_q]) + 64'(rwn));
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k1_q  <= cmd_i.rd_word;
    k2_q  <= k1_q;
    m2_q  <= m;
    pp2_q <= 64'(m) * 64'(off_sel);
    pn2_q <= 48'(m) * 48'(nrm_sel);
    r3_q  <= k2_q[3:2];
    r4_q  <= r3_q;
    pfin_q <= pacc_q + 50'(m2_q);
    nfin_q <= nacc_q;
    wp_q  <= 50'(ps) * 50'($signed({1'b0, w_q}));
    wn_q  <= 50'(ns) * 50'($signed({1'b0, w_q}));
    if (cmd_i.emit) begin
      opx_q <= psum_q[0];
      opy_q <= psum_q[1];
      opz_q <= psum_q[2];
      onx_q <= nsum_q[0];
      ony_q <= nsum_q[1];
      onz_q <= nsum_q[2];
    end
  end

  assign in_i.ready   = cmd_i.in_ready;
  assign out_o.valid  = out_valid_q;
  assign out_o.pos_x  = opx_q;
  assign out_o.pos_y  = opy_q;
  assign out_o.pos_z  = opz_q;
  assign out_o.norm_x = onx_q;
  assign out_o.norm_y = ony_q;
  assign out_o.norm_z = onz_q;

  assign stat_o.in_valid     = in_i.valid;
  assign stat_o.in_is_weight = in_i.command == CMD_WEIGHT;
  assign stat_o.in_bone_ok   = 32'(in_i.bone_index) < 32'(MAX_BONES);
  assign stat_o.in_last      = in_i.last_weight;
  assign stat_o.last_q       = last_q;
  assign stat_o.rows_done    = v4_q && (r4_q == 2'd2);
  assign stat_o.out_free     = !out_valid_q || out_o.ready;

endmodule

### design/skeletal_vertex_skinning_core.sv
`timescale 1ns / 1ps
// Linear blend skinning core with frame blending; matrix words, offsets and
// results are signed Q16.16. A weight word walks the 12 words of its bone
// matrix through the single read port of the palette memory, one word a cycle,
// then drains a five-stage multiply-accumulate pipe; on the last weight the
// result is then placed in the output register once it is free. A weight whose
// bone is out of range fetches nothing. The output register lets the next word
// be accepted while a result waits. The palette needs no clearing.
// depends on svs_pkg, svs_in_if, svs_out_if, svs_ctrl, svs_datapath
module skeletal_vertex_skinning_core
  import svs_pkg::*;
#(
  parameter int MAX_BONES = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  svs_in_if.sink      in_i,
  svs_out_if.source   out_o
);

  svs_cmd_t  cmd;
  svs_stat_t stat;

  svs_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .stat_i(stat),
    .cmd_o (cmd)
  );

  svs_datapath #(
    .MAX_BONES(MAX_BONES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_i       (in_i),
    .out_o      (out_o)
  );

endmodule

### sim/skeletal_vertex_skinning_core_tb.sv
`timescale 1ns / 1ps
// self-checking bench for the skinning core: blended bone loads, weighted vertices
// depends on svs_pkg, svs_in_if, svs_out_if and skeletal_vertex_skinning_core
module skeletal_vertex_skinning_core_tb;
  import svs_pkg::*;

  localparam int NBONES   = 128;
  localparam int PAL_SIZE = NBONES * WORDS_PER_BONE;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic signed [31:0] px, py, pz, nx, ny, nz;
  } vertex_t;

  // predicts the skinned vertices from accepted words
  class skin_scoreboard;
    longint         palette[PAL_SIZE];
    longint         pos_acc[3];
    longint         nrm_acc[3];
    int unsigned    blend_frac;
    vertex_t        pending[$];
    int             errors;

    function longint rnd_shift(longint x, int s);
      return (x + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function longint clip(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function void note_word(logic cmd, logic [10:0] slot, logic signed [31:0] nv,
                            logic signed [31:0] ov, logic [6:0] bone, logic [16:0] wt,
                            logic signed [31:0] ox, logic signed [31:0] oy,
                            logic signed [31:0] oz, logic [31:0] nxy,
                            logic signed [15:0] nz, logic last);
      longint f, w, p, n, m;
      longint off[3], nrm[3];
      vertex_t v;
      if (cmd == CMD_LOAD) begin
        f = (blend_frac > ONE_Q16) ? ONE_Q16 : blend_frac;
        if (slot < PAL_SIZE)
          palette[slot] = clip(rnd_shift(longint'(nv) * (ONE_Q16 - f) + longint'(ov) * f, 16));
        return;
      end
      w = (wt > ONE_Q16) ? ONE_Q16 : wt;
      off[0] = ox; off[1] = oy; off[2] = oz;
      nrm[0] = $signed(nxy[31:16]); nrm[1] = $signed(nxy[15:0]); nrm[2] = nz;
      if (bone < NBONES) begin
        for (int r = 0; r < 3; r++) begin
          p = palette[bone * WORDS_PER_BONE + r * 4 + 3];
          n = 0;
          for (int c = 0; c < 3; c++) begin
            m = palette[bone * WORDS_PER_BONE + r * 4 + c];
            p += rnd_shift(m * off[c], 16);
            n += m * nrm[c];
          end
          pos_acc[r] = clip(pos_acc[r] + rnd_shift(clip(p) * w, 16));
          nrm_acc[r] = clip(nrm_acc[r] + rnd_shift(clip(rnd_shift(n, 14)) * w, 16));
        end
      end
      if (last) begin
        v.px = pos_acc[0]; v.py = pos_acc[1]; v.pz = pos_acc[2];
        v.nx = nrm_acc[0]; v.ny = nrm_acc[1]; v.nz = nrm_acc[2];
        pending.push_back(v);
        for (int r = 0; r < 3; r++) begin
          pos_acc[r] = 0;
          nrm_acc[r] = 0;
        end
      end
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t exp_v;
      if (pending.size() == 0) begin
        $error("unexpected vertex out");
        errors++;
        return;
      end
      exp_v = pending.pop_front();
      if (got.px !== exp_v.px) begin $error("pos_x exp %0d got %0d", exp_v.px, got.px); errors++; end
      if (got.py !== exp_v.py) begin $error("pos_y exp %0d got %0d", exp_v.py, got.py); errors++; end
      if (got.pz !== exp_v.pz) begin $error("pos_z exp %0d got %0d", exp_v.pz, got.pz); errors++; end
      if (got.nx !== exp_v.nx) begin $error("norm_x exp %0d got %0d", exp_v.nx, got.nx); errors++; end
      if (got.ny !== exp_v.ny) begin $error("norm_y exp %0d got %0d", exp_v.ny, got.ny); errors++; end
      if (got.nz !== exp_v.nz) begin $error("norm_z exp %0d got %0d", exp_v.nz, got.nz); errors++; end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [16:0] cfg_wdata_i = '0;

  svs_in_if  in_ch ();
  svs_out_if out_ch ();

  skeletal_vertex_skinning_core #(.MAX_BONES(NBONES)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  always #5 clk_i = ~clk_i;

  skin_scoreboard sb;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  quiet_cycles;
  bit  bone_full[NBONES];

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = CMD_LOAD;
    in_ch.bone_slot = '0;
    in_ch.new_value = '0;
    in_ch.old_value = '0;
    in_ch.bone_index = '0;
    in_ch.weight = '0;
    in_ch.offset_x = '0;
    in_ch.offset_y = '0;
    in_ch.offset_z = '0;
    in_ch.normal_packed_xy = '0;
    in_ch.normal_z = '0;
    in_ch.last_weight = 1'b0;
    out_ch.ready = 1'b0;
  end

  // receiver side and scoring
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_vertex({out_ch.pos_x, out_ch.pos_y, out_ch.pos_z,
                         out_ch.norm_x, out_ch.norm_y, out_ch.norm_z});
      if (in_ch.valid && in_ch.ready)
        sb.note_word(in_ch.command, in_ch.bone_slot, in_ch.new_value, in_ch.old_value,
                     in_ch.bone_index, in_ch.weight, in_ch.offset_x, in_ch.offset_y,
                     in_ch.offset_z, in_ch.normal_packed_xy, in_ch.normal_z,
                     in_ch.last_weight);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // valid stays high between back-to-back words; idling or draining lowers it
  task automatic send_word(logic cmd, logic [10:0] slot, logic [31:0] nv, logic [31:0] ov,
                           logic [6:0] bone, logic [16:0] wt, logic [31:0] ox,
                           logic [31:0] oy, logic [31:0] oz, logic [31:0] nxy,
                           logic [15:0] nz, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.bone_slot <= slot;
    in_ch.new_value <= nv;
    in_ch.old_value <= ov;
    in_ch.bone_index <= bone;
    in_ch.weight <= wt;
    in_ch.offset_x <= ox;
    in_ch.offset_y <= oy;
    in_ch.offset_z <= oz;
    in_ch.normal_packed_xy <= nxy;
    in_ch.normal_z <= nz;
    in_ch.last_weight <= last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic load_word(int slot, logic [31:0] nv, logic [31:0] ov);
    send_word(CMD_LOAD, 11'(slot), nv, ov, 7'($urandom), 17'($urandom), $urandom, $urandom,
              $urandom, $urandom, 16'($urandom), 1'($urandom));
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(131072) - 65536;
      3: return $urandom;
      default: return $signed($urandom_range(1 << 20)) - (1 << 19);
    endcase
  endfunction

  function automatic logic [16:0] rand_weight();
    case ($urandom_range(4))
      0: return 17'd65536;
      1: return 17'd0;
      2: return 17'(32'd65536 + $urandom_range(65535));
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  task automatic load_bone(int bone);
    for (int k = 0; k < WORDS_PER_BONE; k++)
      load_word(bone * WORDS_PER_BONE + k, rand_val(), rand_val());
    bone_full[bone] = 1'b1;
  endtask

  // a weight on a bone is only sent once all twelve of its words exist
  function automatic logic [6:0] pick_bone();
    int b;
    b = $urandom_range(NBONES - 1);
    for (int k = 0; k < NBONES; k++)
      if (bone_full[(b + k) % NBONES]) return 7'((b + k) % NBONES);
    return 7'd0;
  endfunction

  task automatic weight_word(logic [6:0] bone, logic [16:0] wt, logic last);
    send_word(CMD_WEIGHT, 11'($urandom), $urandom, $urandom, bone, wt, rand_val(), rand_val(),
              rand_val(), $urandom, 16'($urandom), last);
  endtask

  task automatic drain_and_config(logic [16:0] frac);
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= frac;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.blend_frac = frac;
  endtask

  task automatic random_phase(int n);
    int b;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: begin
          b = $urandom_range(NBONES - 1);
          load_bone(b);
          i += 11;
        end
        1: load_word(PAL_SIZE + $urandom_range(2047 - PAL_SIZE), $urandom, $urandom);
        2: weight_word(pick_bone(), rand_weight(), 1'($urandom_range(1)));
        default: weight_word(pick_bone(), rand_weight(), $urandom_range(3) == 0);
      endcase
    end
    weight_word(pick_bone(), rand_weight(), 1'b1);
  endtask

  initial begin
    sb = new();
    sb.errors = 0;
    sb.blend_frac = 0;
    for (int r = 0; r < 3; r++) begin
      sb.pos_acc[r] = 0;
      sb.nrm_acc[r] = 0;
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    quiet_cycles = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: extremes of the words and weights
    load_word(0, 32'h7FFFFFFF, 32'h80000000);
    load_word(1, 32'h80000000, 32'h7FFFFFFF);
    for (int k = 2; k < WORDS_PER_BONE; k++) load_word(k, 32'h00010000, 32'hFFFF0000);
    bone_full[0] = 1'b1;
    load_word(2047, 32'h12345678, 32'h0);
    load_word(PAL_SIZE, 32'h1, 32'h1);
    weight_word(0, 17'd65536, 1'b0);
    send_word(CMD_WEIGHT, 0, 0, 0, 0, 17'h1FFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
              32'h80007FFF, 16'h8000, 1'b0);
    weight_word(0, 17'd0, 1'b1);
    weight_word(7'd0, 17'd65536, 1'b1);
    load_bone(NBONES - 1);
    weight_word(NBONES - 1, 17'd32768, 1'b1);

    drain_and_config(17'd65536);
    load_bone(1);
    weight_word(1, 17'd65536, 1'b1);
    drain_and_config(17'h1FFFF);
    load_bone(2);
    weight_word(2, 17'd65535, 1'b1);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      case (ph)
        0: drain_and_config(17'd0);
        3: drain_and_config(17'd1);
        5: drain_and_config(17'd65536);
        7: drain_and_config(17'($urandom_range(65535)));
        default: ;
      endcase
      random_phase(250);
    end

    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

### filelist.f
design/svs_pkg.sv
design/svs_in_if.sv
design/svs_out_if.sv
design/svs_ram.sv
design/svs_ctrl.sv
design/svs_datapath.sv
design/skeletal_vertex_skinning_core.sv
sim/skeletal_vertex_skinning_core_tb.sv
